>>> rtl/core/mte_pkg.sv
// Shared types and constants for the MIDI track event encoder.
`default_nettype none

package mte_pkg;

  typedef enum logic [1:0] {
    CMD_TEMPO = 2'd0,
    CMD_NOTE  = 2'd1,
    CMD_EOT   = 2'd2
  } cmd_e;

  localparam int DELTA_BITS_DEFAULT = 32;
  localparam int QUEUE_DEPTH        = 2;
  localparam int MAX_BYTES          = 8;
  localparam int IDX_W              = $clog2(MAX_BYTES);

  localparam logic [23:0] TEMPO_RESET     = 24'd500000;
  localparam logic [7:0]  VLQ_MASK        = 8'h7f;
  localparam logic [7:0]  VLQ_CONT        = 8'h80;
  localparam logic [7:0]  STATUS_NOTE_ON  = 8'h90;
  localparam logic [7:0]  STATUS_NOTE_OFF = 8'h80;
  localparam logic [7:0]  META_PREFIX     = 8'hff;
  localparam logic [7:0]  META_TEMPO      = 8'h51;
  localparam logic [7:0]  META_TEMPO_LEN  = 8'h03;
  localparam logic [7:0]  META_EOT        = 8'h2f;

  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] data;
    logic [IDX_W-1:0]          last;
  } desc_t;

endpackage

`default_nettype wire

>>> rtl/core/mte_front.sv
// Front end: accepts commands, tracks the previous tick and builds byte descriptors.
`default_nettype none

module mte_front #(
  parameter int DELTA_BITS = mte_pkg::DELTA_BITS_DEFAULT
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          s_tvalid,
  output logic               s_tready,
  input  wire logic [47:0]   s_tdata,
  input  wire logic [2:0]    s_tuser,
  input  wire logic          cfg_valid_i,
  output logic               cfg_ready_o,
  input  wire logic [23:0]   cfg_data_i,
  output logic               push_o,
  output mte_pkg::desc_t     push_desc_o,
  input  wire logic          push_ready_i
);

  localparam int NG = (DELTA_BITS + 6) / 7;
  localparam int PW = NG * 7;

  logic [23:0]            tempo_q;
  logic [DELTA_BITS-1:0]  prev_q, prev_d;
  logic                   st_valid_q, st_valid_d;
  mte_pkg::cmd_e          st_cmd_q;
  logic [DELTA_BITS-1:0]  st_delta_q;
  logic                   st_on_q;
  logic [6:0]             st_pitch_q;
  logic [6:0]             st_vel_q;

  mte_pkg::cmd_e          in_cmd;
  logic                   in_known;
  logic                   accept;
  logic [PW-1:0]          delta_ext;
  logic [2:0]             top;
  logic [7:0]             status;
  logic [7:0]             vel;
  mte_pkg::desc_t         note_desc;
  mte_pkg::desc_t         desc;

  assign cfg_ready_o = 1'b1;
  assign s_tready    = !st_valid_q || push_ready_i;
  assign accept      = s_tvalid && s_tready;
  assign in_cmd      = mte_pkg::cmd_e'(s_tuser[1:0]);
  assign push_o      = st_valid_q && push_ready_i;
  assign push_desc_o = desc;

  always_comb begin
    in_known = 1'b0;
    prev_d   = prev_q;
    unique case (in_cmd)
      mte_pkg::CMD_TEMPO: begin
        in_known = 1'b1;
      end
      mte_pkg::CMD_NOTE: begin
        in_known = 1'b1;
        prev_d   = s_tdata[DELTA_BITS-1:0];
      end
      mte_pkg::CMD_EOT: begin
        in_known = 1'b1;
        prev_d   = '0;
      end
      default: begin
        in_known = 1'b0;
      end
    endcase
  end

  always_comb begin
    st_valid_d = st_valid_q;
    if (accept) begin
      st_valid_d = in_known;
    end else if (push_o) begin
      st_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tempo_q    <= mte_pkg::TEMPO_RESET;
      prev_q     <= '0;
      st_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        tempo_q <= cfg_data_i;
      end
      if (accept) begin
        prev_q <= prev_d;
      end
      st_valid_q <= st_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      st_cmd_q   <= in_cmd;
      st_delta_q <= s_tdata[DELTA_BITS-1:0] - prev_q;
      st_on_q    <= s_tuser[2];
      st_pitch_q <= s_tdata[38:32];
      st_vel_q   <= s_tdata[45:39];
    end
  end

  // Variable-length quantity: highest nonzero seven-bit group first.
  assign delta_ext = PW'(st_delta_q);
  assign status    = st_on_q ? mte_pkg::STATUS_NOTE_ON : mte_pkg::STATUS_NOTE_OFF;

  always_comb begin
    vel = '0;
    if (st_on_q) begin
      vel = (st_vel_q == '0) ? 8'd1 : {1'b0, st_vel_q};
    end
  end

  always_comb begin
    top = '0;
    for (int k = 1; k < NG; k++) begin
      if (delta_ext[k*7 +: 7] != '0) begin
        top = 3'(k);
      end
    end
  end

  always_comb begin
    note_desc      = '0;
    note_desc.last = top + 3'd3;
    for (int j = 0; j < mte_pkg::MAX_BYTES; j++) begin
      if (3'(j) <= top) begin
        for (int k = 0; k < NG; k++) begin
          if (3'(k) + 3'(j) == top) begin
            note_desc.data[j] = ((3'(j) != top) ? mte_pkg::VLQ_CONT : 8'h00)
                              | ({1'b0, delta_ext[k*7 +: 7]} & mte_pkg::VLQ_MASK);
          end
        end
      end else if (3'(j) == top + 3'd1) begin
        note_desc.data[j] = status;
      end else if (3'(j) == top + 3'd2) begin
        note_desc.data[j] = {1'b0, st_pitch_q};
      end else if (3'(j) == top + 3'd3) begin
        note_desc.data[j] = vel;
      end
    end
  end

  always_comb begin
    desc = '0;
    unique case (st_cmd_q)
      mte_pkg::CMD_TEMPO: begin
        desc.data[1] = mte_pkg::META_PREFIX;
        desc.data[2] = mte_pkg::META_TEMPO;
        desc.data[3] = mte_pkg::META_TEMPO_LEN;
        desc.data[4] = tempo_q[23:16];
        desc.data[5] = tempo_q[15:8];
        desc.data[6] = tempo_q[7:0];
        desc.last    = 3'd6;
      end
      mte_pkg::CMD_NOTE: begin
        desc = note_desc;
      end
      mte_pkg::CMD_EOT: begin
        desc.data[1] = mte_pkg::META_PREFIX;
        desc.data[2] = mte_pkg::META_EOT;
        desc.last    = 3'd3;
      end
      default: begin
        desc = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/core/mte_queue.sv
// Small descriptor queue between the front end and the byte sequencer.
`default_nettype none

module mte_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire mte_pkg::desc_t  push_desc_i,
  output logic                 push_ready_o,
  input  wire logic            pop_i,
  output mte_pkg::desc_t       pop_desc_o,
  output logic                 pop_valid_o
);

  localparam int DEPTH = mte_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  mte_pkg::desc_t    mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;

  assign push_ready_o = (cnt_q != CNT_W'(DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_desc_o   = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_desc_i;
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (push_ready_o || pop_i))
    else $error("descriptor pushed into a full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> pop_valid_o)
    else $error("descriptor popped from an empty queue");
`endif

endmodule

`default_nettype wire

>>> rtl/core/mte_back.sv
// Byte sequencer: one descriptor byte per unstalled cycle into the output register.
`default_nettype none

module mte_back (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      pop_valid_i,
  input  wire mte_pkg::desc_t            pop_desc_i,
  output logic                           pop_o,
  output logic                           m_tvalid,
  input  wire logic                      m_tready,
  output logic [7:0]                     m_tdata,
  output logic                           m_tlast
);

  mte_pkg::desc_t              desc_q, desc_d;
  logic [mte_pkg::IDX_W-1:0]   idx_q, idx_d;
  logic                        busy_q, busy_d;
  logic                        out_valid_q, out_valid_d;
  logic [7:0]                  out_data_q, out_data_d;
  logic                        out_last_q, out_last_d;
  logic                        out_free;
  logic                        at_last;

  assign out_free = !out_valid_q || m_tready;
  assign at_last  = (idx_q == desc_q.last);
  assign pop_o    = pop_valid_i && (!busy_q || (out_free && at_last));
  assign m_tvalid = out_valid_q;
  assign m_tdata  = out_data_q;
  assign m_tlast  = out_last_q;

  always_comb begin
    desc_d      = desc_q;
    idx_d       = idx_q;
    busy_d      = busy_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    out_last_d  = out_last_q;
    if (out_free) begin
      out_valid_d = busy_q;
      if (busy_q) begin
        out_data_d = desc_q.data[idx_q];
        out_last_d = at_last;
        idx_d      = idx_q + 1'b1;
        if (at_last) begin
          busy_d = 1'b0;
        end
      end
    end
    if (pop_o) begin
      desc_d = pop_desc_i;
      idx_d  = '0;
      busy_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    desc_q     <= desc_d;
    out_data_q <= out_data_d;
    out_last_q <= out_last_d;
  end

`ifndef SYNTH
  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (idx_q <= desc_q.last))
    else $error("byte index ran past the end of the descriptor");
  a_load_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (busy_q && idx_q == '0))
    else $error("new descriptor did not start at its first byte");
`endif

endmodule

`default_nettype wire

>>> rtl/core/midi_track_event_encoder.sv
// Each accepted item goes through the front-end stage register, the descriptor queue
// and the sequencer to the single output byte register, one byte per cycle unless
// m_tready stalls; an item is 4 to 8 bytes (tempo 7, end of track 4, note 4 to 8).
// A two-entry descriptor queue lets the input keep taking items while bytes drain.
// Reset is asynchronous and active low; it clears the previous tick, sets the tempo
// to 500000 and empties the queue and output register.
`default_nettype none

module midi_track_event_encoder #(
  parameter int DELTA_BITS = mte_pkg::DELTA_BITS_DEFAULT
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [47:0] s_tdata,     // tick[31:0], pitch[38:32], velocity[45:39], zero
  input  wire logic [2:0]  s_tuser,     // command[1:0], note_on[2]
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [23:0] cfg_data_i,  // tempo_micros[23:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,     // out_byte[7:0]
  output logic             m_tlast
);

  logic            push;
  logic            push_ready;
  mte_pkg::desc_t  push_desc;
  logic            pop;
  logic            pop_valid;
  mte_pkg::desc_t  pop_desc;

  mte_front #(
    .DELTA_BITS(DELTA_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .push_o      (push),
    .push_desc_o (push_desc),
    .push_ready_i(push_ready)
  );

  mte_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_desc_i (push_desc),
    .push_ready_o(push_ready),
    .pop_i       (pop),
    .pop_desc_o  (pop_desc),
    .pop_valid_o (pop_valid)
  );

  mte_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pop_valid_i(pop_valid),
    .pop_desc_i (pop_desc),
    .pop_o      (pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast)
  );

endmodule

`default_nettype wire

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench that streams track commands into the MIDI event encoder.
module tb;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int IDLE_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 16;
  localparam int RANDOM_PER_PHASE = 65;
  localparam int NUM_PHASES = 6;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] tick;
    logic        note_on;
    logic [6:0]  pitch;
    logic [6:0]  velocity;
  } track_cmd_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } track_byte_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic [2:0]  s_tuser = '0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [23:0] cfg_data_i = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic        m_tlast;

  track_cmd_t  cmd_pending_q[$];
  track_cmd_t  cmd_on_bus;
  track_byte_t track_bytes_q[$];
  logic [31:0] prior_tick = '0;
  logic [23:0] tempo_setting = mte_pkg::TEMPO_RESET;
  logic [31:0] gen_tick = '0;
  bit          no_idle = 1'b0;
  int          src_gap = 0;
  int          snk_gap = 0;
  int          err_cnt = 0;
  int          idle_cycles = 0;

  midi_track_event_encoder u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tlast     (m_tlast)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic void push_byte(input logic [7:0] b, input logic l);
    track_byte_t item;
    item.data = b;
    item.last = l;
    track_bytes_q.insert(track_bytes_q.size(), item);
  endfunction

  function automatic void encode_event(input track_cmd_t c);
    logic [31:0] delta;
    logic [31:0] grp;
    int          groups;
    case (c.command)
      mte_pkg::CMD_TEMPO: begin
        push_byte(8'h00, 1'b0);
        push_byte(mte_pkg::META_PREFIX, 1'b0);
        push_byte(mte_pkg::META_TEMPO, 1'b0);
        push_byte(mte_pkg::META_TEMPO_LEN, 1'b0);
        push_byte(tempo_setting[23:16], 1'b0);
        push_byte(tempo_setting[15:8], 1'b0);
        push_byte(tempo_setting[7:0], 1'b1);
      end
      mte_pkg::CMD_NOTE: begin
        delta = c.tick - prior_tick;
        prior_tick = c.tick;
        groups = 1;
        while (groups < 5 && (delta >> (7 * groups)) != 0) groups++;
        for (int i = groups - 1; i >= 0; i--) begin
          grp = delta >> (7 * i);
          push_byte({i != 0, grp[6:0]}, 1'b0);
        end
        push_byte(c.note_on ? mte_pkg::STATUS_NOTE_ON : mte_pkg::STATUS_NOTE_OFF, 1'b0);
        push_byte({1'b0, c.pitch}, 1'b0);
        if (!c.note_on) begin
          push_byte(8'h00, 1'b1);
        end else if (c.velocity == 7'd0) begin
          push_byte(8'h01, 1'b1);
        end else begin
          push_byte({1'b0, c.velocity}, 1'b1);
        end
      end
      mte_pkg::CMD_EOT: begin
        push_byte(8'h00, 1'b0);
        push_byte(mte_pkg::META_PREFIX, 1'b0);
        push_byte(mte_pkg::META_EOT, 1'b0);
        push_byte(8'h00, 1'b1);
        prior_tick = '0;
      end
      default: begin
      end
    endcase
  endfunction

  function automatic void queue_cmd(input logic [1:0] cmd, input logic [31:0] t,
                                    input logic on, input logic [6:0] p,
                                    input logic [6:0] v);
    track_cmd_t c;
    c = '{command: cmd, tick: t, note_on: on, pitch: p, velocity: v};
    cmd_pending_q.insert(cmd_pending_q.size(), c);
  endfunction

  // Notes mostly advance from the last generated tick with deltas of every VLQ length.
  function automatic track_cmd_t random_cmd();
    track_cmd_t c;
    int         pick;
    int         width;
    pick = $urandom_range(0, 99);
    c.tick = $urandom;
    c.note_on = 1'($urandom_range(0, 1));
    c.pitch = 7'($urandom);
    c.velocity = ($urandom_range(0, 7) == 0) ? 7'd0 : 7'($urandom);
    if (pick < 10) begin
      c.command = mte_pkg::CMD_TEMPO;
    end else if (pick < 91) begin
      c.command = mte_pkg::CMD_NOTE;
      if ($urandom_range(0, 9) != 0) begin
        width = $urandom_range(0, 32);
        c.tick = gen_tick + ($urandom >> (32 - width));
      end
      gen_tick = c.tick;
    end else if (pick < 97) begin
      c.command = mte_pkg::CMD_EOT;
      gen_tick = '0;
    end else begin
      c.command = CMD_UNUSED;
    end
    return c;
  endfunction

  task automatic wait_idle();
    while (cmd_pending_q.size() != 0 || s_tvalid || track_bytes_q.size() != 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_tempo(input logic [23:0] value);
    cfg_data_i <= value;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    tempo_setting = value;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_tvalid && s_tready) begin
        encode_event(cmd_on_bus);
      end
      if (!s_tvalid || s_tready) begin
        if (src_gap != 0) begin
          src_gap--;
          s_tvalid <= 1'b0;
        end else if (cmd_pending_q.size() != 0) begin
          cmd_on_bus = cmd_pending_q.pop_front();
          s_tdata <= {2'b00, cmd_on_bus.velocity, cmd_on_bus.pitch, cmd_on_bus.tick};
          s_tuser <= {cmd_on_bus.note_on, cmd_on_bus.command};
          s_tvalid <= 1'b1;
          if (!no_idle && $urandom_range(0, 5) == 0) src_gap = $urandom_range(1, 11);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin : byte_monitor
    track_byte_t want;
    if (rst_ni) begin
      if (m_tvalid && m_tready) begin
        if (track_bytes_q.size() == 0) begin
          $error("unexpected transaction: out_byte %02h last_byte %0b", m_tdata, m_tlast);
          err_cnt++;
        end else begin
          want = track_bytes_q.pop_front();
          if (m_tdata !== want.data) begin
            $error("out_byte: expected %02h, actual %02h", want.data, m_tdata);
            err_cnt++;
          end
          if (m_tlast !== want.last) begin
            $error("last_byte: expected %0b, actual %0b", want.last, m_tlast);
            err_cnt++;
          end
        end
      end
      if (snk_gap != 0) begin
        snk_gap--;
        m_tready <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 9) == 0) begin
        snk_gap = $urandom_range(0, 10);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    logic [31:0] t;
    logic [31:0] steps[9];
    logic [23:0] tempos[NUM_PHASES];
    steps = '{32'h7f, 32'h80, 32'h3fff, 32'h4000, 32'h1fffff, 32'h200000,
              32'h0fffffff, 32'h10000000, 32'h1};
    tempos = '{24'h000000, 24'hffffff, 24'($urandom), 24'h000001, 24'($urandom),
               mte_pkg::TEMPO_RESET};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // The first tempo event checks the tempo value left by reset.
    queue_cmd(mte_pkg::CMD_TEMPO, 32'h0, 1'b0, 7'd0, 7'd0);
    queue_cmd(mte_pkg::CMD_NOTE, 32'h0, 1'b1, 7'd0, 7'd0);
    t = 32'h0;
    foreach (steps[i]) begin
      t = t + steps[i];
      queue_cmd(mte_pkg::CMD_NOTE, t, i[0], (i == 0) ? 7'd127 : 7'($urandom),
                (i == 0) ? 7'd127 : 7'd64);
    end
    queue_cmd(mte_pkg::CMD_NOTE, t - 32'h1, 1'b1, 7'd60, 7'd127);
    queue_cmd(mte_pkg::CMD_NOTE, 32'hffffffff, 1'b0, 7'd127, 7'd0);
    queue_cmd(mte_pkg::CMD_NOTE, 32'h0, 1'b1, 7'd1, 7'd1);
    queue_cmd(CMD_UNUSED, 32'hffffffff, 1'b1, 7'd127, 7'd127);
    queue_cmd(mte_pkg::CMD_EOT, 32'hffffffff, 1'b1, 7'd127, 7'd127);
    queue_cmd(mte_pkg::CMD_NOTE, 32'h5, 1'b1, 7'd64, 7'd100);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_idle();
      write_tempo(tempos[ph]);
      if (ph == NUM_PHASES - 1) no_idle = 1'b1;
      gen_tick = prior_tick;
      queue_cmd(mte_pkg::CMD_TEMPO, 32'h0, 1'b0, 7'd0, 7'd0);
      repeat (RANDOM_PER_PHASE) cmd_pending_q.insert(cmd_pending_q.size(), random_cmd());
    end

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (err_cnt == 0 && track_bytes_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
